// File: hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the DV audio sample decoder.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: hw/rtl/dvasd_pkg.sv
// ---------------------------------------------------------------------------
// dvasd_pkg
// Types, constants and the 12-bit nonlinear expansion for the decoder.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dvasd_pkg;

  localparam int QUEUE_DEPTH_DEFAULT = 2;

  localparam logic [11:0] CODE_ERROR   = 12'h800;
  localparam logic [15:0] VALUE_ERROR  = 16'h8000;
  localparam logic [3:0]  NIB_POS_MIN  = 4'h2;
  localparam logic [3:0]  NIB_NEG_MIN  = 4'h8;
  localparam logic [3:0]  NIB_NEG_MAX  = 4'hd;
  localparam logic [3:0]  NIB_NEG_BASE = 4'he;

  localparam logic MODE_LINEAR16 = 1'b0;
  localparam logic MODE_PAIR12   = 1'b1;

  // One queued item, already decoded: one or two samples.
  typedef struct packed {
    logic             pair;     // two samples, left then right
    logic             ch;       // channel of a single sample
    logic [1:0]       damaged;  // per sample slot
    logic [1:0][15:0] value;    // per sample slot
  } dvasd_entry_t;

  // Piecewise nonlinear expansion of a 12-bit two's complement code.
  function automatic logic [15:0] expand12(input logic [11:0] code);
    logic [3:0]         nib;
    logic [2:0]         s;
    logic signed [16:0] v;
    logic signed [16:0] t;
    nib = code[11:8];
    v   = 17'(signed'(code));
    t   = v;
    s   = 3'd0;
    if (nib >= NIB_POS_MIN && nib < NIB_NEG_MIN) begin
      s = 3'(nib - 4'd1);
      t = (v - $signed({6'd0, s, 8'h00})) <<< s;
    end else if (nib >= NIB_NEG_MIN && nib <= NIB_NEG_MAX) begin
      s = 3'(NIB_NEG_BASE - nib);
      t = ((v + $signed({6'd0, s, 8'h01})) <<< s) - 17'sd1;
    end
    return t[15:0];
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/dvasd_front.sv
// ---------------------------------------------------------------------------
// dvasd_front
// Accept items, decode them into samples and flag damage.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dvasd_front (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_we,
  input  wire logic                cfg_wdata,
  input  wire logic                byte_valid,
  output logic                     byte_stall,
  input  wire logic [7:0]          first_byte,
  input  wire logic [7:0]          second_byte,
  input  wire logic [7:0]          third_byte,
  input  wire logic                channel_select,
  input  wire logic                block_present,
  input  wire logic                q_full,
  output logic                     q_push,
  output dvasd_pkg::dvasd_entry_t  q_data
);
  import dvasd_pkg::*;

  logic        sample_mode;
  logic [11:0] code_left;
  logic [11:0] code_right;
  logic [15:0] linear;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_mode <= MODE_LINEAR16;
    end else if (cfg_we) begin
      sample_mode <= cfg_wdata;
    end
  end

  assign byte_stall = q_full;
  assign q_push     = byte_valid && !q_full;

  assign code_left  = {first_byte, third_byte[7:4]};
  assign code_right = {second_byte, third_byte[3:0]};
  assign linear     = {first_byte, second_byte};

  always_comb begin
    q_data = '0;
    if (sample_mode == MODE_PAIR12) begin
      q_data.pair       = 1'b1;
      q_data.ch         = 1'b0;
      q_data.damaged[0] = !block_present || code_left == CODE_ERROR;
      q_data.damaged[1] = !block_present || code_right == CODE_ERROR;
      q_data.value[0]   = expand12(code_left);
      q_data.value[1]   = expand12(code_right);
    end else begin
      q_data.pair       = 1'b0;
      q_data.ch         = channel_select;
      q_data.damaged[0] = !block_present || linear == VALUE_ERROR;
      q_data.damaged[1] = 1'b0;
      q_data.value[0]   = linear;
      q_data.value[1]   = 16'h0000;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/dvasd_queue.sv
// ---------------------------------------------------------------------------
// dvasd_queue
// Short FIFO of decoded items between the front and back parts.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module dvasd_queue #(
  parameter int DEPTH = dvasd_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    push,
  input  wire dvasd_pkg::dvasd_entry_t push_data,
  output logic                         full,
  input  wire logic                    pop,
  output logic                         head_valid,
  output dvasd_pkg::dvasd_entry_t      head
);
  import dvasd_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  dvasd_entry_t  entries [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full       = count == CW'(DEPTH);
  assign head_valid = count != '0;
  assign head       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  `ASSERT_IMPLIES(a_no_overflow, clk, rst, push, !full)
  `ASSERT_IMPLIES(a_no_underflow, clk, rst, pop, head_valid)
  `ASSERT_IMPLIES(a_count_bound, clk, rst, 1'b1, count <= CW'(DEPTH))

endmodule

`default_nettype wire

// File: hw/rtl/dvasd_back.sv
// ---------------------------------------------------------------------------
// dvasd_back
// Emit one sample per cycle while pcm_stall is low, conceal damage, hold the output register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module dvasd_back (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    q_valid,
  input  wire dvasd_pkg::dvasd_entry_t q_head,
  output logic                         q_pop,
  output logic                         pcm_valid,
  input  wire logic                    pcm_stall,
  output logic signed [15:0]           pcm_sample,
  output logic                         sample_channel,
  output logic                         was_concealed,
  output logic                         last_of_item
);
  import dvasd_pkg::*;

  logic        sub;
  logic [15:0] last_good [2];
  logic        cur_idx;
  logic        cur_ch;
  logic        cur_dmg;
  logic [15:0] cur_val;
  logic        cur_last;
  logic        load;

  always_comb begin
    cur_idx  = q_head.pair ? sub : 1'b0;
    cur_ch   = q_head.pair ? sub : q_head.ch;
    cur_dmg  = q_head.damaged[cur_idx];
    cur_val  = q_head.value[cur_idx];
    cur_last = !q_head.pair || sub;
  end

  assign load  = q_valid && (!pcm_valid || !pcm_stall);
  assign q_pop = load && cur_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      pcm_valid    <= 1'b0;
      sub          <= 1'b0;
      last_good[0] <= 16'h0000;
      last_good[1] <= 16'h0000;
    end else begin
      if (load) begin
        pcm_valid <= 1'b1;
        sub       <= q_head.pair ? !sub : 1'b0;
        if (!cur_dmg) begin
          last_good[cur_ch] <= cur_val;
        end
      end else if (!pcm_stall) begin
        pcm_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pcm_sample     <= $signed(cur_dmg ? last_good[cur_ch] : cur_val);
      sample_channel <= cur_ch;
      was_concealed  <= cur_dmg;
      last_of_item   <= cur_last;
    end
  end

  `ASSERT_IMPLIES(a_first_is_left, clk, rst, pcm_valid && !last_of_item,
                  !sample_channel)
  `ASSERT_IMPLIES(a_good_tracks_out, clk, rst, pcm_valid && !was_concealed,
                  last_good[sample_channel] == $unsigned(pcm_sample))
  `ASSERT_IMPLIES(a_pop_at_end, clk, rst, q_pop, !q_head.pair || sub)

endmodule

`default_nettype wire

// File: hw/rtl/dv_audio_sample_decode.sv
// ---------------------------------------------------------------------------
// dv_audio_sample_decode
// DV audio sample decoder with per-channel damage concealment.
// ---------------------------------------------------------------------------
// Decodes DV audio sample bytes to 16-bit PCM. With sample_mode 0 an item is
// one big-endian sample for channel_select and yields one result; with
// sample_mode 1 an item holds two packed 12-bit codes and yields a left and
// then a right result, each widened by the nonlinear DV expansion. An error
// code (0x800), a linear value of 0x8000, or an absent block is replaced by
// the last good sample of that channel (zero after reset) and flagged with
// was_concealed. Rate: the output register moves one result per cycle while
// pcm_stall is low; an accepted item is written into the queue and then
// loaded into the output register. The front decodes and pushes whole items
// into a short queue, so input is taken while results wait on pcm_stall
// until the queue is full. Write sample_mode only while idle. No clearing
// pass after reset.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dv_audio_sample_decode #(
  parameter int QUEUE_DEPTH = dvasd_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  wire logic         clk,
  input  wire logic         rst,
  // configuration: sample_mode
  input  wire logic         cfg_we,
  input  wire logic         cfg_wdata,
  // input items
  input  wire logic         byte_valid,
  output logic              byte_stall,
  input  wire logic [7:0]   first_byte,
  input  wire logic [7:0]   second_byte,
  input  wire logic [7:0]   third_byte,
  input  wire logic         channel_select,
  input  wire logic         block_present,
  // result items
  output logic              pcm_valid,
  input  wire logic         pcm_stall,
  output logic signed [15:0] pcm_sample,
  output logic              sample_channel,
  output logic              was_concealed,
  output logic              last_of_item
);
  import dvasd_pkg::*;

  logic         q_push;
  logic         q_full;
  logic         q_pop;
  logic         q_valid;
  dvasd_entry_t q_data;
  dvasd_entry_t q_head;

  // Front: hold the mode register, decode and classify each item.
  dvasd_front u_front (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .byte_valid     (byte_valid),
    .byte_stall     (byte_stall),
    .first_byte     (first_byte),
    .second_byte    (second_byte),
    .third_byte     (third_byte),
    .channel_select (channel_select),
    .block_present  (block_present),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_data         (q_data)
  );

  // Queue: decouple item intake from result delivery.
  dvasd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_data  (q_data),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head       (q_head)
  );

  // Back: split items into samples, conceal damage, drive results.
  dvasd_back u_back (
    .clk            (clk),
    .rst            (rst),
    .q_valid        (q_valid),
    .q_head         (q_head),
    .q_pop          (q_pop),
    .pcm_valid      (pcm_valid),
    .pcm_stall      (pcm_stall),
    .pcm_sample     (pcm_sample),
    .sample_channel (sample_channel),
    .was_concealed  (was_concealed),
    .last_of_item   (last_of_item)
  );

endmodule

`default_nettype wire
